// File: design/bssr_pkg.sv
// Package for the bracket scope skip recovery block.
// Token and outcome codes, the per-token result struct and the kind decode.
// No dependencies.
`timescale 1ns / 1ps

package bssr_pkg;

  localparam int unsigned TokW   = 3;
  localparam int unsigned KindW  = 2;
  localparam int unsigned OutcW  = 2;
  localparam int unsigned DepthW = 5;
  localparam int unsigned AccW   = 3;

  typedef enum logic [TokW-1:0] {
    TOK_OTHER     = 3'd0,
    TOK_OPEN_CRL  = 3'd1,
    TOK_CLOSE_CRL = 3'd2,
    TOK_OPEN_PAR  = 3'd3,
    TOK_CLOSE_PAR = 3'd4,
    TOK_OPEN_SQR  = 3'd5,
    TOK_CLOSE_SQR = 3'd6,
    TOK_EOF       = 3'd7
  } tok_t;

  typedef enum logic [OutcW-1:0] {
    OC_SKIPPING   = 2'd0,
    OC_DONE       = 2'd1,
    OC_PUSH_FALSE = 2'd2,
    OC_PUSH_TRUE  = 2'd3
  } outcome_t;

  typedef struct packed {
    logic [OutcW-1:0]  outcome;
    logic [DepthW-1:0] stack_depth;
    logic              clear_mute;
    logic              overflow;
  } res_t;

  // bracket kind: 0 curly, 1 paren, 2 square
  function automatic logic [KindW-1:0] tok_kind(input logic [TokW-1:0] tok);
    logic [KindW-1:0] k;
    case (tok)
      TOK_OPEN_CRL, TOK_CLOSE_CRL: k = 2'd0;
      TOK_OPEN_PAR, TOK_CLOSE_PAR: k = 2'd1;
      TOK_OPEN_SQR, TOK_CLOSE_SQR: k = 2'd2;
      default:                     k = 2'd0;
    endcase
    return k;
  endfunction

endpackage

// File: design/bssr_in_if.sv
// Token channel: valid/ready handshake carrying one token kind.
// Depends on bssr_pkg for widths.
`timescale 1ns / 1ps

interface bssr_in_if;
  logic                      valid;
  logic                      ready;
  logic [bssr_pkg::TokW-1:0] token_kind;

  modport source (output valid, output token_kind, input ready);
  modport sink   (input valid, input token_kind, output ready);
endinterface

// File: design/bssr_out_if.sv
// Result channel: valid/ready handshake carrying one skip result.
// Depends on bssr_pkg for widths.
`timescale 1ns / 1ps

interface bssr_out_if;
  logic                        valid;
  logic                        ready;
  logic [bssr_pkg::OutcW-1:0]  outcome;
  logic [bssr_pkg::DepthW-1:0] stack_depth;
  logic                        clear_mute;
  logic                        overflow;

  modport source (output valid, output outcome, output stack_depth,
                  output clear_mute, output overflow, input ready);
  modport sink   (input valid, input outcome, input stack_depth,
                  input clear_mute, input overflow, output ready);
endinterface

// File: design/bssr_scope.sv
// Scope stack and skip decision: one token per step, result combinational.
// Depends on bssr_pkg.
`timescale 1ns / 1ps

module bssr_scope #(
  parameter int unsigned MAX_NEST = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          step,
  input  logic [bssr_pkg::TokW-1:0]     tok,
  input  logic [bssr_pkg::AccW-1:0]     outer_accept,
  output bssr_pkg::res_t                res
);

  localparam int unsigned CntW = $clog2(MAX_NEST + 1);
  localparam int unsigned IdxW = (MAX_NEST > 1) ? $clog2(MAX_NEST) : 1;

  logic [bssr_pkg::KindW-1:0] stk_r [MAX_NEST];
  logic [CntW-1:0]            cnt_r, cnt_nxt;

  logic [bssr_pkg::KindW-1:0] kind;
  logic                       is_open, is_close, is_eof, caller_takes;
  logic                       found, push_en;
  logic [IdxW-1:0]            idx;
  logic [CntW-1:0]            idx_p1;

  always_comb begin
    kind         = bssr_pkg::tok_kind(tok);
    is_eof       = (tok == bssr_pkg::TOK_EOF);
    is_open      = (tok == bssr_pkg::TOK_OPEN_CRL) || (tok == bssr_pkg::TOK_OPEN_PAR) ||
                   (tok == bssr_pkg::TOK_OPEN_SQR);
    is_close     = (tok == bssr_pkg::TOK_CLOSE_CRL) || (tok == bssr_pkg::TOK_CLOSE_PAR) ||
                   (tok == bssr_pkg::TOK_CLOSE_SQR);
    caller_takes = is_close && outer_accept[kind];
  end

  // nearest live entry of this kind: highest index wins
  always_comb begin
    found = 1'b0;
    idx   = '0;
    for (int i = 0; i < MAX_NEST; i++) begin
      if ((CntW'(i) < cnt_r) && (stk_r[i] == kind)) begin
        found = 1'b1;
        idx   = IdxW'(i);
      end
    end
    idx_p1 = CntW'(idx) + CntW'(1);
  end

  always_comb begin
    cnt_nxt         = cnt_r;
    push_en         = 1'b0;
    res.outcome     = bssr_pkg::OC_SKIPPING;
    res.clear_mute  = 1'b0;
    res.overflow    = 1'b0;
    if (cnt_r == '0) begin
      if (is_eof || caller_takes) begin
        res.outcome = bssr_pkg::OC_PUSH_FALSE;
      end else if (is_open) begin
        push_en = 1'b1;
        cnt_nxt = CntW'(1);
      end else begin
        res.outcome = bssr_pkg::OC_DONE;
      end
    end else if (is_open) begin
      if (cnt_r == CntW'(MAX_NEST)) begin
        res.overflow = 1'b1;
      end else begin
        push_en = 1'b1;
        cnt_nxt = cnt_r + CntW'(1);
      end
    end else if (is_close) begin
      if (found) begin
        cnt_nxt        = CntW'(idx);
        res.clear_mute = (idx_p1 != cnt_r);
        res.outcome    = (idx == '0) ? bssr_pkg::OC_DONE : bssr_pkg::OC_SKIPPING;
      end else if (caller_takes) begin
        cnt_nxt        = '0;
        res.clear_mute = 1'b1;
        res.outcome    = bssr_pkg::OC_PUSH_TRUE;
      end
    end else if (is_eof) begin
      cnt_nxt        = '0;
      res.clear_mute = 1'b1;
      res.outcome    = bssr_pkg::OC_PUSH_TRUE;
    end
    res.stack_depth = bssr_pkg::DepthW'(cnt_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (step) begin
      cnt_r <= cnt_nxt;
    end
  end

  // entries at or above the count are never read, so no reset here
  always_ff @(posedge clk) begin
    if (step && push_en) begin
      stk_r[cnt_r[IdxW-1:0]] <= kind;
    end
  end

endmodule

// File: design/bracket_scope_skip_recovery.sv
// Top level of the bracket scope skip recovery block.
// Depends on bssr_pkg, bssr_in_if, bssr_out_if and bssr_scope.
//
// Usage:
//   in_tok carries one token kind per transaction, out_res one result per
//   token, in token order. cfg_we/cfg_wdata write the 3-bit outer_accept
//   mask (curly, paren, square closers taken by the caller); write it only
//   while no token is in flight.
//   A token lands in an input register; once the output buffer has room,
//   the scope stack lookup and update run in one pass and the result is
//   written to a two-entry output buffer, which drives out_res.valid.
//   Throughput is one token per cycle while the buffer has room, set by
//   the combinational priority compare across all MAX_NEST stack entries.
//   When the receiver stalls, the output buffer fills (two results plus
//   one in the input register) and in_tok.ready then drops until results
//   are taken; nothing is dropped.
//   Reset (rst_n low, synchronous) empties the scope stack, the buffer and
//   the input register and clears outer_accept. Stack entries themselves
//   are not cleared; only entries below the count are ever read.
`timescale 1ns / 1ps

module bracket_scope_skip_recovery #(
  parameter int unsigned MAX_NEST = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [bssr_pkg::AccW-1:0] cfg_wdata,
  bssr_in_if.sink                   in_tok,
  bssr_out_if.source                out_res
);

  logic [bssr_pkg::AccW-1:0] acc_r;
  logic                      s1_v_r;
  logic [bssr_pkg::TokW-1:0] s1_tok_r;
  bssr_pkg::res_t            head_r, tail_r, res;
  logic [1:0]                cnt_r, cnt_nxt;
  logic                      in_fire, step, pop;

  always_comb begin
    in_tok.ready = !s1_v_r || (cnt_r != 2'd2);
    in_fire      = in_tok.valid && in_tok.ready;
    step         = s1_v_r && (cnt_r != 2'd2);
    pop          = out_res.valid && out_res.ready;
    cnt_nxt      = cnt_r + {1'b0, step} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else if (cfg_we) begin
      acc_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_fire) begin
      s1_v_r <= 1'b1;
    end else if (step) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_tok_r <= in_tok.token_kind;
    end
  end

  bssr_scope #(
    .MAX_NEST (MAX_NEST)
  ) u_scope (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (step),
    .tok          (s1_tok_r),
    .outer_accept (acc_r),
    .res          (res)
  );

  // two-entry output buffer, head is the oldest result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (cnt_r == 2'd2) begin
        head_r <= tail_r;
      end else if (step) begin
        head_r <= res;
      end
    end else if (step) begin
      if (cnt_r == 2'd0) begin
        head_r <= res;
      end else begin
        tail_r <= res;
      end
    end
  end

  always_comb begin
    out_res.valid       = (cnt_r != 2'd0);
    out_res.outcome     = head_r.outcome;
    out_res.stack_depth = head_r.stack_depth;
    out_res.clear_mute  = head_r.clear_mute;
    out_res.overflow    = head_r.overflow;
  end

endmodule

// File: tb/sv/bracket_scope_skip_recovery_checker.sv
// Scoreboard for bracket_scope_skip_recovery: predicts each token's skip result.
// Depends on bssr_pkg, bssr_in_if and bssr_out_if; watches both channels and cfg.
`timescale 1ns / 1ps

module bracket_scope_skip_recovery_checker #(
  parameter int unsigned MAX_NEST = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [bssr_pkg::AccW-1:0] cfg_wdata,
  bssr_in_if                        in_tok,
  bssr_out_if                       out_res,
  output int unsigned               fail_count,
  output int unsigned               pending
);

  logic [bssr_pkg::KindW-1:0] scope_kind [MAX_NEST];
  int unsigned                scope_cnt;
  logic [bssr_pkg::AccW-1:0]  accept_mask;
  bssr_pkg::res_t             token_results_q [$];
  int unsigned                n_tok;
  int unsigned                n_res;

  assign pending = n_tok - n_res;

  function automatic bssr_pkg::res_t skip_token(input logic [bssr_pkg::TokW-1:0] tok);
    bssr_pkg::res_t             r;
    logic                       is_open;
    logic                       is_close;
    logic                       taken;
    logic [bssr_pkg::KindW-1:0] kind;
    int unsigned                lvl;
    is_open  = (tok == bssr_pkg::TOK_OPEN_CRL) || (tok == bssr_pkg::TOK_OPEN_PAR) ||
               (tok == bssr_pkg::TOK_OPEN_SQR);
    is_close = (tok == bssr_pkg::TOK_CLOSE_CRL) || (tok == bssr_pkg::TOK_CLOSE_PAR) ||
               (tok == bssr_pkg::TOK_CLOSE_SQR);
    kind     = (is_open || is_close) ? bssr_pkg::KindW'((tok - 1) >> 1) : '0;
    taken    = is_close && accept_mask[kind];
    r.outcome    = bssr_pkg::OC_SKIPPING;
    r.clear_mute = 1'b0;
    r.overflow   = 1'b0;
    if (scope_cnt == 0) begin
      if (tok == bssr_pkg::TOK_EOF || taken) begin
        r.outcome = bssr_pkg::OC_PUSH_FALSE;
      end else if (is_open) begin
        scope_kind[0] = kind;
        scope_cnt     = 1;
      end else begin
        r.outcome = bssr_pkg::OC_DONE;
      end
    end else if (is_open) begin
      if (scope_cnt >= MAX_NEST) begin
        r.overflow = 1'b1;
      end else begin
        scope_kind[scope_cnt] = kind;
        scope_cnt++;
      end
    end else if (is_close) begin
      // nearest stacked opener of the same kind wins over the caller's mask
      lvl = scope_cnt;
      while (lvl > 0 && scope_kind[lvl-1] != kind) lvl--;
      if (lvl > 0) begin
        r.clear_mute = (lvl < scope_cnt);
        scope_cnt    = lvl - 1;
        if (scope_cnt == 0) r.outcome = bssr_pkg::OC_DONE;
      end else if (taken) begin
        scope_cnt    = 0;
        r.outcome    = bssr_pkg::OC_PUSH_TRUE;
        r.clear_mute = 1'b1;
      end
    end else if (tok == bssr_pkg::TOK_EOF) begin
      scope_cnt    = 0;
      r.outcome    = bssr_pkg::OC_PUSH_TRUE;
      r.clear_mute = 1'b1;
    end
    r.stack_depth = bssr_pkg::DepthW'(scope_cnt);
    return r;
  endfunction

  always @(posedge clk) begin : track
    bssr_pkg::res_t want;
    int unsigned    errs;
    errs = 0;
    if (!rst_n) begin
      scope_cnt   = 0;
      accept_mask = '0;
      token_results_q.delete();
      n_tok      <= 0;
      n_res      <= 0;
      fail_count <= 0;
    end else begin
      if (cfg_we) accept_mask = cfg_wdata;
      if (in_tok.valid && in_tok.ready) begin
        token_results_q.push_back(skip_token(in_tok.token_kind));
        n_tok <= n_tok + 1;
      end
      if (out_res.valid && out_res.ready) begin
        n_res <= n_res + 1;
        if (token_results_q.size() == 0) begin
          $error("result transaction with no token waiting");
          errs++;
        end else begin
          want = token_results_q.pop_front();
          if (out_res.outcome !== want.outcome) begin
            $error("outcome: expected %0d, got %0d", want.outcome, out_res.outcome);
            errs++;
          end
          if (out_res.stack_depth !== want.stack_depth) begin
            $error("stack_depth: expected %0d, got %0d", want.stack_depth,
                   out_res.stack_depth);
            errs++;
          end
          if (out_res.clear_mute !== want.clear_mute) begin
            $error("clear_mute: expected %0d, got %0d", want.clear_mute,
                   out_res.clear_mute);
            errs++;
          end
          if (out_res.overflow !== want.overflow) begin
            $error("overflow: expected %0d, got %0d", want.overflow, out_res.overflow);
            errs++;
          end
        end
      end
      if (errs != 0) fail_count <= fail_count + errs;
    end
  end

endmodule

// File: tb/sv/bracket_scope_skip_recovery_tb.sv
// Testbench top for bracket_scope_skip_recovery: token stimulus, cfg writes, verdict.
// Depends on bssr_pkg, the channel interfaces, bracket_scope_skip_recovery and its checker.
`timescale 1ns / 1ps

module bracket_scope_skip_recovery_tb;

  localparam int unsigned PhaseItems = 150;
  localparam int unsigned MaxNest    = 16;

  logic                      clk;
  logic                      rst_n;
  logic                      cfg_we;
  logic [bssr_pkg::AccW-1:0] cfg_wdata;
  int unsigned               fail_count;
  int unsigned               pending;
  int unsigned               send_idle;
  int unsigned               recv_idle;
  int unsigned               tok_sent;

  bssr_in_if  tok_ch ();
  bssr_out_if res_ch ();

  bracket_scope_skip_recovery #(.MAX_NEST(MaxNest)) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_tok    (tok_ch),
    .out_res   (res_ch)
  );

  bracket_scope_skip_recovery_checker #(.MAX_NEST(MaxNest)) u_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tok     (tok_ch),
    .out_res    (res_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

  always @(posedge clk) begin
    res_ch.ready <= ($urandom_range(99) >= recv_idle);
  end

  function automatic logic [bssr_pkg::TokW-1:0] opener_of(
    input logic [bssr_pkg::KindW-1:0] k);
    return bssr_pkg::TokW'(2 * k + 1);
  endfunction

  function automatic logic [bssr_pkg::TokW-1:0] closer_of(
    input logic [bssr_pkg::KindW-1:0] k);
    return bssr_pkg::TokW'(2 * k + 2);
  endfunction

  // returns at the edge where the transaction is taken, valid still high
  task automatic send_tok(input logic [bssr_pkg::TokW-1:0] tok);
    while ($urandom_range(99) < send_idle) begin
      tok_ch.valid <= 1'b0;
      @(posedge clk);
    end
    tok_ch.valid      <= 1'b1;
    tok_ch.token_kind <= tok;
    @(posedge clk);
    while (!tok_ch.ready) @(posedge clk);
    tok_sent++;
  endtask

  task automatic drain();
    tok_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_accept(input logic [bssr_pkg::AccW-1:0] mask);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= mask;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // mostly balanced nesting with random content, some stray closers and eof
  task automatic run_scope_group();
    logic [bssr_pkg::KindW-1:0] open_kinds [$];
    logic [bssr_pkg::KindW-1:0] k;
    int unsigned                target;
    int unsigned                steps;
    int unsigned                pick;
    target = ($urandom_range(7) == 0) ? $urandom_range(14, 18) : $urandom_range(1, 5);
    k = bssr_pkg::KindW'($urandom_range(2));
    open_kinds.push_back(k);
    send_tok(opener_of(k));
    steps = 0;
    while (open_kinds.size() > 0 && steps < 80) begin
      pick = $urandom_range(99);
      if (open_kinds.size() < target && pick < 45) begin
        k = bssr_pkg::KindW'($urandom_range(2));
        open_kinds.push_back(k);
        send_tok(opener_of(k));
      end else if (pick < 75) begin
        send_tok(closer_of(open_kinds.pop_back()));
      end else if (pick < 85) begin
        send_tok(bssr_pkg::TOK_OTHER);
      end else if (pick < 92) begin
        send_tok(closer_of(bssr_pkg::KindW'($urandom_range(2))));
      end else if (pick < 95) begin
        send_tok(bssr_pkg::TOK_EOF);
        open_kinds.delete();
      end else begin
        send_tok(bssr_pkg::TokW'($urandom_range(7)));
      end
      steps++;
    end
  endtask

  initial begin : stim
    logic [bssr_pkg::AccW-1:0] plan [6];
    int unsigned               phase_end;
    rst_n             <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_wdata         <= '0;
    tok_ch.valid      <= 1'b0;
    tok_ch.token_kind <= '0;
    send_idle = 18;
    recv_idle = 75;
    tok_sent  = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // idle cases with nothing accepted by the caller
    send_tok(bssr_pkg::TOK_EOF);
    send_tok(bssr_pkg::TOK_OTHER);
    send_tok(bssr_pkg::TOK_CLOSE_CRL);
    // fill the stack, then one opener too many
    for (int i = 0; i < 17; i++) send_tok(opener_of(bssr_pkg::KindW'(i % 3)));
    send_tok(bssr_pkg::TOK_CLOSE_PAR);
    send_tok(bssr_pkg::TOK_OTHER);
    send_tok(bssr_pkg::TOK_EOF);

    write_accept(3'd7);
    send_tok(bssr_pkg::TOK_CLOSE_SQR);
    send_tok(bssr_pkg::TOK_OPEN_CRL);
    send_tok(bssr_pkg::TOK_CLOSE_CRL);
    send_tok(bssr_pkg::TOK_OPEN_SQR);
    send_tok(bssr_pkg::TOK_CLOSE_CRL);

    plan[0] = 3'd0;
    plan[1] = 3'd7;
    for (int i = 2; i < 6; i++) plan[i] = bssr_pkg::AccW'($urandom_range(7));
    for (int p = 0; p < 6; p++) begin
      if (p == 2) begin
        send_idle = 75;
        recv_idle = 18;
      end else if (p == 4) begin
        send_idle = 0;
        recv_idle = 0;
      end
      write_accept(plan[p]);
      phase_end = tok_sent + PhaseItems;
      while (tok_sent < phase_end) begin
        if ($urandom_range(3) == 0) send_tok(bssr_pkg::TokW'($urandom_range(7)));
        else run_scope_group();
      end
    end

    drain();
    repeat (4) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: bracket_scope_skip_recovery.f
design/bssr_pkg.sv
design/bssr_in_if.sv
design/bssr_out_if.sv
design/bssr_scope.sv
design/bracket_scope_skip_recovery.sv
tb/sv/bracket_scope_skip_recovery_checker.sv
tb/sv/bracket_scope_skip_recovery_tb.sv
